// ===== hw/rtl/packet_queue_lifetime_discard_unit_defines.svh =====
// ----------------------------------------------------------------------------
// packet queue lifetime discard unit: assertion macros
// shared concurrent assertion forms, clocked on clk and quiet in reset
// ----------------------------------------------------------------------------
`ifndef PACKET_QUEUE_LIFETIME_DISCARD_UNIT_DEFINES_SVH
`define PACKET_QUEUE_LIFETIME_DISCARD_UNIT_DEFINES_SVH

// property that must hold at every edge out of reset
`define PQLD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication over time, out of reset
`define PQLD_ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== hw/rtl/pqld_pkg.sv =====
// ----------------------------------------------------------------------------
// pqld_pkg
// types, constants and codes of the packet queue lifetime discard unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pqld_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_W      = 3;
  localparam int HANDLE_W    = 16;
  localparam int TICK_W      = 32;
  localparam int CNT_FIELD_W = 5;

  localparam int IN_FIELDS_W  = MODE_W + HANDLE_W + TICK_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = HANDLE_W + 3 + 2 * CNT_FIELD_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_ENQ_TAIL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENQ_HEAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEQ      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH    = 3'd4;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TICK_W-1:0]   stamp;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_TAIL,
    CELL_FROM_HEAD,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    logic             shift_to_head;
    logic             shift_to_tail;
    logic             load_tail;
    logic [IDX_W-1:0] tail_idx;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EXEC
  } state_t;

endpackage

// ===== hw/rtl/pqld_cell.sv =====
// ----------------------------------------------------------------------------
// pqld_cell
// one queue slot: holds a handle and its stamp, takes a neighbor or a new word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqld_cell (
  input  logic              clk,
  input  pqld_pkg::cell_op_t op,
  input  pqld_pkg::entry_t  head_side,
  input  pqld_pkg::entry_t  tail_side,
  input  pqld_pkg::entry_t  load_entry,
  output pqld_pkg::entry_t  entry
);
  import pqld_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    case (op)
      CELL_FROM_TAIL: entry_nxt = tail_side;
      CELL_FROM_HEAD: entry_nxt = head_side;
      CELL_LOAD:      entry_nxt = load_entry;
      default:        entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== hw/rtl/pqld_ctrl.sv =====
// ----------------------------------------------------------------------------
// pqld_ctrl
// sequencer: expiry walk, queue operation, occupancy and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pqld_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pqld_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pqld_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pqld_pkg::TICK_W-1:0]         cfg_data,
  input  pqld_pkg::entry_t                    head_entry,
  output pqld_pkg::entry_t                    new_entry,
  output pqld_pkg::cell_ctl_t                 cell_ctl
);
  import pqld_pkg::*;

  `include "packet_queue_lifetime_discard_unit_defines.svh"

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic [TICK_W-1:0]   now_r, now_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    dropped_r, dropped_nxt;
  logic [TICK_W-1:0]   lifetime_r, lifetime_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                in_acc;
  logic                walk_mode;
  logic [TICK_W-1:0]   age;
  logic                expired;
  logic                full;
  logic                out_free;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_valid;
  logic                res_ovf;
  logic [CNT_W:0]      walk_total;

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign walk_mode = (in_tdata[MODE_W-1:0] == MODE_ENQ_TAIL) ||
                     (in_tdata[MODE_W-1:0] == MODE_ENQ_HEAD) ||
                     (in_tdata[MODE_W-1:0] == MODE_DEQ) ||
                     (in_tdata[MODE_W-1:0] == MODE_PEEK);
  assign age      = now_r - head_entry.stamp;
  assign expired  = (count_r != '0) && (age >= lifetime_r);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign out_free = !out_valid_r || out_tready;

  assign walk_total = {1'b0, count_r} + {1'b0, dropped_r};

  assign new_entry.handle = handle_r;
  assign new_entry.stamp  = now_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = walk_mode ? ST_WALK : ST_EXEC;
        end
      end
      ST_WALK: begin
        if (!expired) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt      = mode_r;
    handle_nxt    = handle_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    lifetime_nxt  = lifetime_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cell_ctl      = '0;
    cell_ctl.tail_idx = count_r[IDX_W-1:0];
    res_handle    = '0;
    res_valid     = 1'b0;
    res_ovf       = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      lifetime_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt    = in_tdata[MODE_W-1:0];
          handle_nxt  = in_tdata[MODE_W +: HANDLE_W];
          now_nxt     = in_tdata[MODE_W + HANDLE_W +: TICK_W];
          dropped_nxt = '0;
        end
      end
      ST_WALK: begin
        if (expired) begin
          cell_ctl.shift_to_head = 1'b1;
          count_nxt   = count_r - 1'b1;
          dropped_nxt = dropped_r + 1'b1;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          case (mode_r)
            MODE_ENQ_TAIL: begin
              if (full) begin
                res_ovf = 1'b1;
              end else begin
                cell_ctl.load_tail = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_ENQ_HEAD: begin
              if (full) begin
                res_ovf = 1'b1;
              end else begin
                cell_ctl.shift_to_tail = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_DEQ: begin
              if (count_r != '0) begin
                res_handle = head_entry.handle;
                res_valid  = 1'b1;
                cell_ctl.shift_to_head = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            MODE_PEEK: begin
              if (count_r != '0) begin
                res_handle = head_entry.handle;
                res_valid  = 1'b1;
              end
            end
            MODE_FLUSH: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({CNT_FIELD_W'(dropped_r), res_ovf,
                                        CNT_FIELD_W'(count_nxt), (count_nxt == '0),
                                        res_valid, res_handle});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= '0;
      lifetime_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      lifetime_r  <= lifetime_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    handle_r   <= handle_nxt;
    now_r      <= now_nxt;
    out_data_r <= out_data_nxt;
  end

  `PQLD_ASSERT_ALWAYS(a_count_bound, (count_r <= CNT_W'(QUEUE_DEPTH)), "occupancy above depth")
  `PQLD_ASSERT_IMPL(a_walk_conserves, (state_r == ST_WALK) |=> (walk_total == $past(walk_total)), "walk lost an entry")
  `PQLD_ASSERT_IMPL(a_exec_posts, (state_r == ST_EXEC && out_free) |=> (out_valid_r && state_r == ST_IDLE), "result not posted")
  `PQLD_ASSERT_IMPL(a_accept_busy, in_acc |=> (state_r != ST_IDLE), "accept did not start work")

endmodule

// ===== hw/rtl/packet_queue_lifetime_discard_unit.sv =====
// ----------------------------------------------------------------------------
// packet_queue_lifetime_discard_unit
// bounded double-ended descriptor queue with lifetime expiry at the head end
// ----------------------------------------------------------------------------
// A word whose mode runs the expiry walk passes from acceptance through the walk
// state, which tests the head cell once per cycle and shifts the row of cells
// toward the head on each discard by lifetime expiry, and then through the
// operation state, whose result is registered; the next word is accepted once
// the unit is back in idle. Flush and unused modes skip the walk and go straight
// to the operation. A finished result sits in an output register, so the
// next word is taken while it waits, but that word's operation stalls until
// the register is free; the queue holds QUEUE_DEPTH entries.
`timescale 1ns / 1ps

module packet_queue_lifetime_discard_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // mode[2:0], packet_handle[18:3], now_ticks[50:19], zero pad
  input  logic [pqld_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // head_handle[15:0], head_valid[16], queue_empty[17], entry_count[22:18],
  // overflow[23], expired_count[28:24], zero pad
  output logic [pqld_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  // msdu_lifetime
  input  logic [pqld_pkg::TICK_W-1:0]       cfg_data
);
  import pqld_pkg::*;

  entry_t    cell_entry [QUEUE_DEPTH];
  entry_t    new_entry;
  cell_ctl_t cell_ctl;

  pqld_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head_entry (cell_entry[0]),
    .new_entry  (new_entry),
    .cell_ctl   (cell_ctl)
  );

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_op_t op;
    entry_t   head_side;
    entry_t   tail_side;

    if (i == 0) begin : g_first
      assign head_side = new_entry;
    end else begin : g_mid
      assign head_side = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign tail_side = cell_entry[i];
    end else begin : g_inner
      assign tail_side = cell_entry[i+1];
    end

    always_comb begin
      if (cell_ctl.shift_to_head) begin
        op = CELL_FROM_TAIL;
      end else if (cell_ctl.shift_to_tail) begin
        op = CELL_FROM_HEAD;
      end else if (cell_ctl.load_tail && (cell_ctl.tail_idx == IDX_W'(i))) begin
        op = CELL_LOAD;
      end else begin
        op = CELL_HOLD;
      end
    end

    pqld_cell u_cell (
      .clk        (clk),
      .op         (op),
      .head_side  (head_side),
      .tail_side  (tail_side),
      .load_entry (new_entry),
      .entry      (cell_entry[i])
    );
  end

endmodule

// ===== dv/packet_queue_lifetime_discard_unit_tb.sv =====
// ----------------------------------------------------------------------------
// packet_queue_lifetime_discard_unit_tb
// Self-checking bench for the descriptor queue with lifetime discard. Words
// go in as mode, handle and tick count. Each result word is checked field by
// field against a queue model that is advanced at input acceptance. The
// directed tests cover the empty queue, the full queue with overflow at
// either end, zero lifetime and the wrapped age at the largest lifetime.
// Random traffic then runs under several lifetime settings, with burst gaps
// on the input, a stall pattern on the output, one long output hold-off and
// one drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_queue_lifetime_discard_unit_tb;
  import pqld_pkg::*;

  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 4;
  localparam int CYCLE_LIMIT      = 600000;
  localparam int SETTLE_CYCLES    = 2 * QUEUE_DEPTH + 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PRINT_LIMIT      = 100;

  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_FLUSH + 3'd1;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;
  localparam logic [TICK_W-1:0] LIFETIME_MAX      = '1;

  typedef struct packed {
    logic [CNT_FIELD_W-1:0] expired_count;
    logic                   overflow;
    logic [CNT_FIELD_W-1:0] entry_count;
    logic                   queue_empty;
    logic                   head_valid;
    logic [HANDLE_W-1:0]    head_handle;
  } queue_status_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // mode, packet_handle, now_ticks, zero pad
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // head_handle, head_valid, queue_empty, entry_count, overflow,
  // expired_count, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [TICK_W-1:0]      cfg_data   = '0;

  packet_queue_lifetime_discard_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // queue model
  logic [HANDLE_W-1:0] model_handle [QUEUE_DEPTH];
  logic [TICK_W-1:0]   model_stamp  [QUEUE_DEPTH];
  int unsigned         model_head     = 0;
  int unsigned         model_tail     = 0;
  int unsigned         model_fill     = 0;
  logic [TICK_W-1:0]   model_lifetime = LIFETIME_MAX;

  queue_status_t expected_status [$];
  int unsigned   error_count  = 0;
  int unsigned   cycle_count  = 0;
  logic [TICK_W-1:0] tick_now = '0;
  int unsigned   enq_weight   = 50;
  bit            gaps_enabled = 1'b1;
  int unsigned   burst_left   = 0;
  bit            hold_request = 1'b0;
  int unsigned   hold_left    = 0;
  logic [15:0]   stall_pattern = '1;
  int unsigned   stall_phase  = 0;

  function automatic queue_status_t predict_status(input logic [MODE_W-1:0] mode,
                                                   input logic [HANDLE_W-1:0] handle,
                                                   input logic [TICK_W-1:0] now);
    queue_status_t st;
    int unsigned dropped;
    logic [TICK_W-1:0] age;
    st = '0;
    dropped = 0;
    if (mode <= MODE_PEEK) begin
      while (model_fill > 0) begin
        age = now - model_stamp[IDX_W'(model_head)];
        if (age < model_lifetime) break;
        model_head = (model_head + 1) % QUEUE_DEPTH;
        model_fill--;
        dropped++;
      end
    end
    case (mode)
      MODE_ENQ_TAIL, MODE_ENQ_HEAD: begin
        if (model_fill >= QUEUE_DEPTH) begin
          st.overflow = 1'b1;
        end else if (mode == MODE_ENQ_TAIL) begin
          model_handle[IDX_W'(model_tail)] = handle;
          model_stamp[IDX_W'(model_tail)]  = now;
          model_tail = (model_tail + 1) % QUEUE_DEPTH;
          model_fill++;
        end else begin
          model_head = (model_head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          model_handle[IDX_W'(model_head)] = handle;
          model_stamp[IDX_W'(model_head)]  = now;
          model_fill++;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (model_fill > 0) begin
          st.head_handle = model_handle[IDX_W'(model_head)];
          st.head_valid  = 1'b1;
          if (mode == MODE_DEQ) begin
            model_head = (model_head + 1) % QUEUE_DEPTH;
            model_fill--;
          end
        end
      end
      MODE_FLUSH: begin
        model_head = 0;
        model_tail = 0;
        model_fill = 0;
      end
      default: ;
    endcase
    st.queue_empty   = (model_fill == 0);
    st.entry_count   = CNT_FIELD_W'(model_fill);
    st.expired_count = CNT_FIELD_W'(dropped);
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [HANDLE_W-1:0] handle,
                           input logic [TICK_W-1:0] now);
    int unsigned gap;
    queue_status_t want_st;
    @(negedge clk);
    in_tdata  <= IN_TDATA_W'({now, handle, mode});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    want_st = predict_status(mode, handle, now);
    expected_status.insert(expected_status.size(), want_st);
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_enabled) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_random_word(input logic [TICK_W-1:0] step_max);
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < enq_weight)
      mode = ($urandom_range(3, 0) == 0) ? MODE_ENQ_HEAD : MODE_ENQ_TAIL;
    else if (pick < 88)
      mode = ($urandom_range(2, 0) == 0) ? MODE_PEEK : MODE_DEQ;
    else if (pick < 92)
      mode = MODE_FLUSH;
    else
      mode = MODE_W'($urandom_range(MODE_UNUSED_LAST, 0));
    case ($urandom_range(7, 0))
      0:       handle = '0;
      1:       handle = '1;
      default: handle = HANDLE_W'($urandom());
    endcase
    if ($urandom_range(49, 0) == 0)
      tick_now = $urandom();
    else
      tick_now = tick_now + $urandom_range(step_max, 0);
    send_word(mode, handle, tick_now);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [TICK_W-1:0] value);
    wait_all_results();
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_lifetime = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_queue();
    send_word(MODE_PEEK, HANDLE_W'($urandom()), 32'd0);
    send_word(MODE_DEQ, HANDLE_W'($urandom()), 32'd0);
    send_word(MODE_UNUSED_FIRST, HANDLE_W'($urandom()), LIFETIME_MAX);
    send_word(MODE_UNUSED_LAST, HANDLE_W'($urandom()), 32'd5);
    send_word(MODE_FLUSH, HANDLE_W'($urandom()), 32'd7);
  endtask

  task automatic test_full_queue();
    logic [HANDLE_W-1:0] handle;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      handle = (i == 0) ? '0 : (i == 1) ? '1 : HANDLE_W'($urandom());
      send_word((i % 2 == 0) ? MODE_ENQ_TAIL : MODE_ENQ_HEAD, handle, 32'd100 + i);
    end
    send_word(MODE_ENQ_TAIL, HANDLE_W'($urandom()), 32'd200);
    send_word(MODE_ENQ_HEAD, HANDLE_W'($urandom()), 32'd201);
  endtask

  task automatic test_expiry_limits();
    // zero lifetime drops the whole full queue in one walk
    write_lifetime('0);
    send_word(MODE_PEEK, HANDLE_W'($urandom()), LIFETIME_MAX);
    // age that wraps to the largest lifetime still expires
    write_lifetime(LIFETIME_MAX);
    send_word(MODE_ENQ_TAIL, HANDLE_W'($urandom()), 32'd1);
    send_word(MODE_PEEK, HANDLE_W'($urandom()), 32'd0);
  endtask

  task automatic test_output_backpressure();
    write_lifetime(32'd2000);
    gaps_enabled = 1'b0;
    enq_weight   = 60;
    hold_request = 1'b1;
    repeat (48) send_random_word(32'd30);
    gaps_enabled = 1'b1;
    wait_all_results();
  endtask

  task automatic test_drain_pause();
    enq_weight = 45;
    repeat (30) send_random_word(32'd50);
    wait_all_results();
    repeat (30) send_random_word(32'd50);
  endtask

  task automatic run_random_phase(input logic [TICK_W-1:0] lifetime,
                                  input logic [TICK_W-1:0] step_max, input int unsigned count);
    write_lifetime(lifetime);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) enq_weight = $urandom_range(75, 30);
      send_random_word(step_max);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(32'd40, 32'd12, 160);
    run_random_phase(32'd1, 32'd2, 140);
    run_random_phase('0, 32'd100, 100);
    tick_now = LIFETIME_MAX - 32'd3000;
    run_random_phase(32'd500, 32'd60, 160);
    run_random_phase(LIFETIME_MAX, LIFETIME_MAX, 140);
    run_random_phase($urandom_range(300, 2), 32'd40, 160);
  endtask

  // receiver: stall pattern, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_pattern = ($urandom_range(2, 0) == 0) ? 16'hFFFF : 16'($urandom());
        stall_phase   = 16;
      end
      stall_phase--;
      out_tready <= stall_pattern[4'(stall_phase)];
    end
  end

  always @(posedge clk) begin : result_check
    queue_status_t got_st;
    queue_status_t want_st;
    if (rst_n && out_tvalid && out_tready) begin
      got_st = queue_status_t'(out_tdata[OUT_FIELDS_W-1:0]);
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected word", 32'(got_st), '0);
      end else begin
        want_st = expected_status.pop_front();
        check_field("head_handle", 32'(got_st.head_handle), 32'(want_st.head_handle));
        check_field("head_valid", 32'(got_st.head_valid), 32'(want_st.head_valid));
        check_field("queue_empty", 32'(got_st.queue_empty), 32'(want_st.queue_empty));
        check_field("entry_count", 32'(got_st.entry_count), 32'(want_st.entry_count));
        check_field("overflow", 32'(got_st.overflow), 32'(want_st.overflow));
        check_field("expired_count", 32'(got_st.expired_count),
                    32'(want_st.expired_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_full_queue();
    test_expiry_limits();
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic();
    wait_all_results();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
